>>> hw/rtl/sttq_pkg.sv
// Shared types and constants of the sorted timer queue.
`timescale 1ns / 1ps
package sttq_pkg;
    localparam int TIDW = 6;
    localparam int EXPW = 32;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_FREE   = 3'd2;
    localparam logic [2:0] OP_INIT   = 3'd3;
    localparam logic [2:0] OP_SET    = 3'd4;
    localparam logic [2:0] OP_CANCEL = 3'd5;
    localparam logic [2:0] OP_CANALL = 3'd6;

    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_PUT  = 2'd1;
    localparam logic [1:0] KIND_TASK = 2'd2;

    localparam logic [1:0] CH_HOLD = 2'd0;
    localparam logic [1:0] CH_INS  = 2'd1;
    localparam logic [1:0] CH_DEL  = 2'd2;
    localparam logic [1:0] CH_POP  = 2'd3;

    typedef struct packed {
        logic            valid;
        logic [TIDW-1:0] id;
        logic [EXPW-1:0] exp;
    } t_cell;

    typedef struct packed {
        logic [1:0]      op;
        logic [TIDW-1:0] key_id;
        logic [EXPW-1:0] key_exp;
    } t_chain_ctl;
endpackage

>>> hw/rtl/sttq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sttq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/sttq_cell.sv
// One slot of the sorted timer chain: holds one running timer.
`timescale 1ns / 1ps
module sttq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sttq_pkg::t_chain_ctl i_ctl,
    input  sttq_pkg::t_cell     i_left,
    input  sttq_pkg::t_cell     i_right,
    input  logic                i_found,
    output logic                o_found,
    output sttq_pkg::t_cell     o_cell
);
    sttq_pkg::t_cell r_cell;
    sttq_pkg::t_cell n_cell;
    logic            w_ins_hit;
    logic            w_del_hit;

    assign w_ins_hit = !r_cell.valid || (r_cell.exp >= i_ctl.key_exp);
    assign w_del_hit = r_cell.valid && (r_cell.id == i_ctl.key_id);

    always_comb begin
        n_cell  = r_cell;
        o_found = i_found;
        case (i_ctl.op)
            sttq_pkg::CH_INS: begin
                o_found = i_found | w_ins_hit;
                if (i_found) begin
                    n_cell = i_left;
                end else if (w_ins_hit) begin
                    n_cell.valid = 1'b1;
                    n_cell.id    = i_ctl.key_id;
                    n_cell.exp   = i_ctl.key_exp;
                end
            end
            sttq_pkg::CH_DEL: begin
                o_found = i_found | w_del_hit;
                if (i_found || w_del_hit) begin
                    n_cell = i_right;
                end
            end
            sttq_pkg::CH_POP: begin
                n_cell = i_right;
            end
            default: begin
                n_cell = r_cell;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

>>> hw/rtl/sttq_chain.sv
// Row of cells holding running timers in list order, head at cell 0.
`timescale 1ns / 1ps
module sttq_chain #(
    parameter int NCELL = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sttq_pkg::t_chain_ctl i_ctl,
    output sttq_pkg::t_cell      o_head,
    output sttq_pkg::t_cell      o_second
);
    sttq_pkg::t_cell w_cell  [NCELL];
    logic            w_found [NCELL+1];

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        sttq_pkg::t_cell w_left;
        sttq_pkg::t_cell w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_cell[g-1];
        end
        if (g == NCELL - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end
        sttq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_found (w_found[g]),
            .o_found (w_found[g+1]),
            .o_cell  (w_cell[g])
        );
    end

    assign o_head = w_cell[0];
    if (NCELL > 1) begin : g_two
        assign o_second = w_cell[1];
    end else begin : g_one
        assign o_second = '0;
    end
endmodule

>>> hw/rtl/sorted_timeout_timer_queue_core.sv
// Sorted timer queue: command sequencer, status flags, event memory, timer chain.
// Allocate, free, init, set, cancel: the command is registered, then its result goes out.
// Tick: done if nothing expired, else an event per expired event timer, read from memory,
// then task if the task timer expired; cancel all: memory sweep. Output stalls hold these.
// Throughput: one command at a time; the sequencer takes a new command once the last is out.
// The timer chain inserts or removes by shifting cells to their neighbors.
// Reset (synchronous, active low): all timers free, entry 0 the sentinel, tick count zero.
`timescale 1ns / 1ps
module sorted_timeout_timer_queue_core #(
    parameter int MAX_TIMERS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: timer_id[5:0], timeout[37:6], fifo_id[45:38], event_data[77:46],
    //        cancellable[78], zero[79]
    input  logic [79:0] i_s_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: out_fifo_id[7:0], out_data[39:8], out_timer_id[45:40], ok[46], zero[47]
    output logic [47:0] o_m_tdata,
    // tuser: kind[1:0]
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    localparam int IW    = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int NCELL = MAX_TIMERS - 1;
    localparam int RAMW  = 40;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_EXP  = 3'd2;
    localparam logic [2:0] S_EVRD = 3'd3;
    localparam logic [2:0] S_SWRD = 3'd4;
    localparam logic [2:0] S_SWCK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [6:0]            r_task;
    logic [31:0]           r_tick, n_tick;
    logic [MAX_TIMERS-1:0] r_used, n_used;
    logic [MAX_TIMERS-1:0] r_run, n_run;
    logic [MAX_TIMERS-1:0] r_canc, n_canc;
    logic                  r_ts, n_ts;
    logic                  r_any, n_any;
    logic [IW-1:0]         r_idx, n_idx;
    logic [5:0]            r_ev_id, n_ev_id;
    logic                  r_ev_last, n_ev_last;

    logic [2:0]  r_op;
    logic [5:0]  r_id;
    logic [31:0] r_timeout;
    logic [7:0]  r_fifo;
    logic [31:0] r_data;
    logic        r_cin;

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_kind, n_out_kind;
    logic [7:0]  r_out_fifo, n_out_fifo;
    logic [31:0] r_out_data, n_out_data;
    logic [5:0]  r_out_tid, n_out_tid;
    logic        r_out_ok, n_out_ok;
    logic        r_out_last, n_out_last;

    sttq_pkg::t_chain_ctl w_ctl;
    sttq_pkg::t_cell      w_head;
    sttq_pkg::t_cell      w_second;

    logic            w_accept;
    logic            w_out_free;
    logic            w_id_ok;
    logic [IW-1:0]   w_ix;
    logic            w_head_exp;
    logic            w_next_exp;
    logic            w_ram_we;
    logic            w_ram_re;
    logic [IW-1:0]   w_ram_raddr;
    logic [RAMW-1:0] w_ram_rdata;
    logic            w_free_hit;
    logic [IW-1:0]   w_free_ix;
    logic [IW-1:0]   w_hix;

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_id_ok     = (r_id != 6'd0) && ({1'b0, r_id} < 7'(MAX_TIMERS));
    assign w_ix        = r_id[IW-1:0];
    assign w_hix       = w_head.id[IW-1:0];
    assign w_head_exp  = w_head.valid && (w_head.exp <= r_tick);
    assign w_next_exp  = w_second.valid && (w_second.exp <= r_tick);

    // lowest free entry for allocate
    always_comb begin
        w_free_hit = 1'b0;
        w_free_ix  = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_hit = 1'b1;
                w_free_ix  = IW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_used      = r_used;
        n_run       = r_run;
        n_canc      = r_canc;
        n_ts        = r_ts;
        n_any       = r_any;
        n_idx       = r_idx;
        n_ev_id     = r_ev_id;
        n_ev_last   = r_ev_last;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind  = r_out_kind;
        n_out_fifo  = r_out_fifo;
        n_out_data  = r_out_data;
        n_out_tid   = r_out_tid;
        n_out_ok    = r_out_ok;
        n_out_last  = r_out_last;
        w_ctl.op      = sttq_pkg::CH_HOLD;
        w_ctl.key_id  = r_id;
        w_ctl.key_exp = r_timeout + r_tick;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == sttq_pkg::OP_TICK) begin
                    n_tick  = r_tick + 32'd1;
                    n_ts    = 1'b0;
                    n_any   = 1'b0;
                    n_state = S_EXP;
                end else if (r_op == sttq_pkg::OP_CANALL) begin
                    n_idx   = IW'(1);
                    n_state = S_SWRD;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = sttq_pkg::KIND_DONE;
                    n_out_fifo  = '0;
                    n_out_data  = '0;
                    n_out_tid   = '0;
                    n_out_ok    = 1'b0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                    case (r_op)
                        sttq_pkg::OP_ALLOC: begin
                            if (w_free_hit) begin
                                n_used[w_free_ix] = 1'b1;
                                n_canc[w_free_ix] = 1'b0;
                                n_out_tid = 6'(w_free_ix);
                                n_out_ok  = 1'b1;
                            end
                        end
                        sttq_pkg::OP_FREE: begin
                            if (w_id_ok) begin
                                if (r_run[w_ix]) begin
                                    w_ctl.op = sttq_pkg::CH_DEL;
                                end
                                n_run[w_ix]  = 1'b0;
                                n_used[w_ix] = 1'b0;
                            end
                        end
                        sttq_pkg::OP_INIT: begin
                            if (w_id_ok) begin
                                w_ram_we     = 1'b1;
                                n_canc[w_ix] = r_cin;
                            end
                        end
                        sttq_pkg::OP_SET: begin
                            if (w_id_ok && r_used[w_ix] && !r_run[w_ix]) begin
                                w_ctl.op    = sttq_pkg::CH_INS;
                                n_run[w_ix] = 1'b1;
                                n_out_ok    = 1'b1;
                            end
                        end
                        sttq_pkg::OP_CANCEL: begin
                            if (w_id_ok && r_run[w_ix]) begin
                                w_ctl.op    = sttq_pkg::CH_DEL;
                                n_run[w_ix] = 1'b0;
                                n_out_ok    = 1'b1;
                            end
                        end
                        default: begin
                            n_out_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_EXP: begin
                if (w_head_exp) begin
                    w_ctl.op     = sttq_pkg::CH_POP;
                    n_run[w_hix] = 1'b0;
                    if ({1'b0, w_head.id} == r_task) begin
                        n_ts = 1'b1;
                    end else begin
                        w_ram_re    = 1'b1;
                        w_ram_raddr = w_hix;
                        n_ev_id     = w_head.id;
                        n_ev_last   = !w_next_exp && !r_ts;
                        n_state     = S_EVRD;
                    end
                end else if (r_ts) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = sttq_pkg::KIND_TASK;
                        n_out_fifo  = '0;
                        n_out_data  = '0;
                        n_out_tid   = r_task[5:0];
                        n_out_ok    = 1'b0;
                        n_out_last  = 1'b1;
                        n_ts        = 1'b0;
                        n_state     = S_IDLE;
                    end
                end else if (!r_any) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = sttq_pkg::KIND_DONE;
                        n_out_fifo  = '0;
                        n_out_data  = '0;
                        n_out_tid   = '0;
                        n_out_ok    = 1'b0;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EVRD: begin
                // hold until the output register can take the event
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = sttq_pkg::KIND_PUT;
                    n_out_fifo  = w_ram_rdata[39:32];
                    n_out_data  = w_ram_rdata[31:0];
                    n_out_tid   = r_ev_id;
                    n_out_ok    = 1'b0;
                    n_out_last  = r_ev_last;
                    n_any       = 1'b1;
                    n_state     = S_EXP;
                end
            end
            S_SWRD: begin
                w_ram_re = 1'b1;
                n_state  = S_SWCK;
            end
            S_SWCK: begin
                if (r_used[r_idx] && r_canc[r_idx] && (w_ram_rdata[39:32] == r_fifo)) begin
                    if (r_run[r_idx]) begin
                        w_ctl.op     = sttq_pkg::CH_DEL;
                        w_ctl.key_id = 6'(r_idx);
                    end
                    n_run[r_idx]  = 1'b0;
                    n_used[r_idx] = 1'b0;
                end
                if (r_idx == IW'(MAX_TIMERS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SWRD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = sttq_pkg::KIND_DONE;
                    n_out_fifo  = '0;
                    n_out_data  = '0;
                    n_out_tid   = '0;
                    n_out_ok    = 1'b0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_task      <= 7'd64;
            r_tick      <= '0;
            r_used      <= MAX_TIMERS'(1);
            r_run       <= MAX_TIMERS'(1);
            r_canc      <= '0;
            r_ts        <= 1'b0;
            r_any       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_used      <= n_used;
            r_run       <= n_run;
            r_canc      <= n_canc;
            r_ts        <= n_ts;
            r_any       <= n_any;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_task <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_s_tuser;
            r_id      <= i_s_tdata[5:0];
            r_timeout <= i_s_tdata[37:6];
            r_fifo    <= i_s_tdata[45:38];
            r_data    <= i_s_tdata[77:46];
            r_cin     <= i_s_tdata[78];
        end
        r_ev_id    <= n_ev_id;
        r_ev_last  <= n_ev_last;
        r_out_kind <= n_out_kind;
        r_out_fifo <= n_out_fifo;
        r_out_data <= n_out_data;
        r_out_tid  <= n_out_tid;
        r_out_ok   <= n_out_ok;
        r_out_last <= n_out_last;
    end

    sttq_chain #(
        .NCELL (NCELL)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .o_head   (w_head),
        .o_second (w_second)
    );

    sttq_ram #(
        .WIDTH (RAMW),
        .DEPTH (MAX_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ix),
        .i_wdata ({r_fifo, r_data}),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {1'b0, r_out_ok, r_out_tid, r_out_data, r_out_fifo};

    a_head_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_head.valid |-> r_run[w_hix])
        else $error("head of chain is not marked running");
    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[0] && r_run[0])
        else $error("sentinel entry lost");
    a_run_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run & ~r_used) == '0)
        else $error("running timer not allocated");
    a_no_head_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP && !w_head_exp) |=> !(r_state == S_EVRD))
        else $error("event read without an expired head");
endmodule
